[rtl/core/quaternion_alu_unit_assert.svh]
// assertion macros shared by the quaternion unit
`ifndef QUATERNION_ALU_UNIT_ASSERT_SVH
`define QUATERNION_ALU_UNIT_ASSERT_SVH

// implication checked on the same edge, masked while in reset
`define QALU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// implication checked at the next edge, not masked by reset
`define QALU_ASSERT_NXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/qalu_pkg.sv]
package qalu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_W           = 32;
    localparam int N_COMP        = 4;

    localparam logic [2:0] FUNC_MUL   = 3'd0;
    localparam logic [2:0] FUNC_DIV   = 3'd1;
    localparam logic [2:0] FUNC_INV   = 3'd2;
    localparam logic [2:0] FUNC_NORMZ = 3'd3;
    localparam logic [2:0] FUNC_NORM  = 3'd4;
    localparam logic [2:0] FUNC_NSQ   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_NORM = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO  = 2'd2;
    localparam logic [1:0] ST_SAT       = 2'd3;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

endpackage

[rtl/core/qalu_isqrt_pipe.sv]
module qalu_isqrt_pipe #(
    parameter int RAD_W  = 66,
    parameter int SIDE_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int NS     = ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic                vld_reg  [NS];
    logic                en       [NS];
    logic [ROOT_W-1:0]   root_reg [NS];
    logic [REM_W-1:0]    rem_reg  [NS];
    logic [RAD_W-1:0]    rad_reg  [NS];
    logic [SIDE_W-1:0]   side_reg [NS];

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_in;
        logic [RAD_W-1:0]  rad_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic              en_down;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  test;
        logic [REM_W+1:0]  diff;
        logic              ge;
        logic [ROOT_W-1:0] root_next;
        logic [REM_W-1:0]  rem_next;
        logic [RAD_W-1:0]  rad_next;

        if (k == 0) begin : g_first
            assign root_in  = '0;
            assign rem_in   = '0;
            assign rad_in   = in_rad;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_follow
            assign root_in  = root_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign rad_in   = rad_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = vld_reg[k-1];
        end

        if (k == NS - 1) begin : g_last
            assign en_down = out_ready;
        end else begin : g_mid
            assign en_down = en[k+1];
        end

        assign en[k]     = ~vld_reg[k] | en_down;
        assign cur       = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign test      = {2'b00, root_in, 2'b01};
        assign ge        = (cur >= test);
        assign diff      = cur - test;
        assign root_next = {root_in[ROOT_W-2:0], ge};
        assign rem_next  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        assign rad_next  = {rad_in[RAD_W-3:0], 2'b00};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en[k]) begin
                vld_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                root_reg[k] <= root_next;
                rem_reg[k]  <= rem_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[rtl/core/qalu_div_pipe.sv]
module qalu_div_pipe
    import qalu_pkg::*;
#(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 49,
    parameter int SIDE_W = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [N_COMP-1:0][NUM_W-1:0]   in_num,
    input  logic [DEN_W-1:0]               in_den,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [N_COMP-1:0][NUM_W-1:0]   out_quo,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int NS = NUM_W;

    logic                            vld_reg  [NS];
    logic                            en       [NS];
    logic [N_COMP-1:0][DEN_W-1:0]    rem_reg  [NS];
    logic [N_COMP-1:0][NUM_W-1:0]    quo_reg  [NS];
    logic [N_COMP-1:0][NUM_W-1:0]    num_reg  [NS];
    logic [DEN_W-1:0]                den_reg  [NS];
    logic [SIDE_W-1:0]               side_reg [NS];

    // restoring division, one quotient bit per stage on all four lanes
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [N_COMP-1:0][DEN_W-1:0] rem_in;
        logic [N_COMP-1:0][NUM_W-1:0] quo_in;
        logic [N_COMP-1:0][NUM_W-1:0] num_in;
        logic [DEN_W-1:0]             den_in;
        logic [SIDE_W-1:0]            side_in;
        logic                         valid_in;
        logic                         en_down;
        logic [N_COMP-1:0][DEN_W-1:0] rem_next;
        logic [N_COMP-1:0][NUM_W-1:0] quo_next;
        logic [N_COMP-1:0][NUM_W-1:0] num_next;

        if (k == 0) begin : g_first
            assign rem_in   = '0;
            assign quo_in   = '0;
            assign num_in   = in_num;
            assign den_in   = in_den;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_follow
            assign rem_in   = rem_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign num_in   = num_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign side_in  = side_reg[k-1];
            assign valid_in = vld_reg[k-1];
        end

        if (k == NS - 1) begin : g_last
            assign en_down = out_ready;
        end else begin : g_mid
            assign en_down = en[k+1];
        end

        assign en[k] = ~vld_reg[k] | en_down;

        always_comb begin
            logic [DEN_W:0] cur;
            logic [DEN_W:0] diff;
            logic           ge;
            rem_next = '0;
            quo_next = '0;
            num_next = '0;
            for (int i = 0; i < N_COMP; i++) begin
                cur  = {rem_in[i], num_in[i][NUM_W-1]};
                ge   = (cur >= {1'b0, den_in});
                diff = cur - {1'b0, den_in};
                rem_next[i] = ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
                quo_next[i] = {quo_in[i][NUM_W-2:0], ge};
                num_next[i] = {num_in[i][NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en[k]) begin
                vld_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                num_reg[k]  <= num_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

[rtl/core/quaternion_alu_unit.sv]
// quaternion arithmetic unit in signed fixed point (FRAC_BITS fraction bits, Q16.16 by default):
// each input word selects one operation on quaternions a and b and a scalar divisor (hamilton
// product, divide by scalar, inverse, normalise, norm, squared norm) and yields exactly one result
// word; out-of-range values saturate with status 3, a zero norm gives zero with status 1 and a
// zero divisor gives zero with status 2. the unit is fully pipelined and takes one word per cycle
// while the output keeps accepting; every word passes the capture, multiply and add front end, the
// bit-serial square root and the bit-serial division on quotients of 32 + FRAC_BITS bits (48 at
// Q16.16), one stage per result bit, then the output register. stages with no word in them let the
// stream close up, so a stalled output only holds the input once the pipe is full
`include "quaternion_alu_unit_assert.svh"

module quaternion_alu_unit
    import qalu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, divisor (32 bits each)
    input  logic [287:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_x, r_y, r_z, r_w, scalar_out (32 bits each)
    output logic [159:0] m_tdata,
    // status
    output logic [1:0]   m_tuser
);

    localparam int SQ_W   = 2 * Q_W + 1;            // exact sum of squares
    localparam int RAD_W  = SQ_W + 1;               // even width for the root
    localparam int ROOT_W = RAD_W / 2;
    localparam int NSQ_W  = SQ_W - FRAC_BITS;       // squared norm before clamping
    localparam int DEN_W  = (NSQ_W > ROOT_W) ? NSQ_W : ROOT_W;
    localparam int NUM_W  = Q_W + FRAC_BITS;
    localparam int HP_W   = 2 * Q_W + 1;            // pair of products
    localparam int H_W    = 2 * Q_W + 2;            // sum of four products

    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(Q_MAX);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(Q_MAX) + NUM_W'(1);

    typedef struct packed {
        logic [2:0]                   func;
        logic [N_COMP-1:0][Q_W-1:0]   a;
        logic [Q_W-1:0]               dv;
        logic [NSQ_W-1:0]             nsq;
        logic [N_COMP-1:0][Q_W-1:0]   mr;
        logic                         msat;
    } sq_side_t;

    typedef struct packed {
        logic                         mulop;
        logic                         qop;
        logic                         zflag;
        logic                         dzflag;
        logic [N_COMP-1:0]            neg;
        logic [Q_W-1:0]               scalar;
        logic                         ssat;
        logic [N_COMP-1:0][Q_W-1:0]   mr;
        logic                         msat;
    } div_side_t;

    // ---- front end: capture, multiply, pair sums, final sums ----
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic en0, en1, en2, en3;
    logic sq_in_ready;

    logic [2:0]              func0_reg, func1_reg, func2_reg;
    logic signed [Q_W-1:0]   a0_reg [N_COMP];
    logic signed [Q_W-1:0]   b0_reg [N_COMP];
    logic signed [Q_W-1:0]   dv0_reg;
    logic [Q_W-1:0]          a1_reg [N_COMP];
    logic [Q_W-1:0]          a2_reg [N_COMP];
    logic [Q_W-1:0]          dv1_reg, dv2_reg;

    logic signed [2*Q_W-1:0] prod_reg [N_COMP][N_COMP];
    logic [2*Q_W-1:0]        sq_reg [N_COMP];
    logic signed [HP_W-1:0]  hp_reg  [N_COMP][2];
    logic signed [HP_W-1:0]  hp_next [N_COMP][2];
    logic [SQ_W-1:0]         sp_reg  [2];
    logic [SQ_W-1:0]         sp_next [2];
    logic [SQ_W-1:0]         sqsum3_reg;
    logic [SQ_W-1:0]         sqsum_next;
    sq_side_t                side3_reg;
    sq_side_t                side3_next;

    // each stage moves on when it is empty or the next one moves
    assign en3      = ~v3_reg | sq_in_ready;
    assign en2      = ~v2_reg | en3;
    assign en1      = ~v1_reg | en2;
    assign en0      = ~v0_reg | en1;
    assign s_tready = en0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en0) v0_reg <= s_tvalid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // stage 0: unpack the input word
    always_ff @(posedge aclk) begin
        if (en0) begin
            func0_reg <= s_tuser;
            for (int i = 0; i < N_COMP; i++) begin
                a0_reg[i] <= s_tdata[i*Q_W +: Q_W];
                b0_reg[i] <= s_tdata[(N_COMP+i)*Q_W +: Q_W];
            end
            dv0_reg <= s_tdata[2*N_COMP*Q_W +: Q_W];
        end
    end

    // stage 1: all sixteen cross products and the four squares
    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int i = 0; i < N_COMP; i++) begin
                for (int j = 0; j < N_COMP; j++) begin
                    prod_reg[i][j] <= a0_reg[i] * b0_reg[j];
                end
                sq_reg[i] <= a0_reg[i] * a0_reg[i];
                a1_reg[i] <= a0_reg[i];
            end
            func1_reg <= func0_reg;
            dv1_reg   <= dv0_reg;
        end
    end

    // stage 2: pair sums, index 0 x, 1 y, 2 z, 3 w
    always_comb begin
        hp_next[0][0] = HP_W'(prod_reg[3][0]) + HP_W'(prod_reg[0][3]);
        hp_next[0][1] = HP_W'(prod_reg[1][2]) - HP_W'(prod_reg[2][1]);
        hp_next[1][0] = HP_W'(prod_reg[3][1]) + HP_W'(prod_reg[1][3]);
        hp_next[1][1] = HP_W'(prod_reg[2][0]) - HP_W'(prod_reg[0][2]);
        hp_next[2][0] = HP_W'(prod_reg[3][2]) + HP_W'(prod_reg[2][3]);
        hp_next[2][1] = HP_W'(prod_reg[0][1]) - HP_W'(prod_reg[1][0]);
        hp_next[3][0] = HP_W'(prod_reg[3][3]) - HP_W'(prod_reg[0][0]);
        hp_next[3][1] = HP_W'(0) - HP_W'(prod_reg[1][1]) - HP_W'(prod_reg[2][2]);
        sp_next[0]    = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
        sp_next[1]    = {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            hp_reg    <= hp_next;
            sp_reg    <= sp_next;
            func2_reg <= func1_reg;
            a2_reg    <= a1_reg;
            dv2_reg   <= dv1_reg;
        end
    end

    // stage 3: product sums floored to the output scale and clamped, plus the full sum of squares
    always_comb begin
        logic signed [H_W-1:0] hsum;
        logic signed [H_W-1:0] hsh;
        logic                  hi_sat;
        logic                  lo_sat;
        side3_next      = '0;
        sqsum_next      = sp_reg[0] + sp_reg[1];
        side3_next.func = func2_reg;
        side3_next.dv   = dv2_reg;
        side3_next.nsq  = sqsum_next[SQ_W-1:FRAC_BITS];
        for (int c = 0; c < N_COMP; c++) begin
            hsum   = H_W'(hp_reg[c][0]) + H_W'(hp_reg[c][1]);
            hsh    = hsum >>> FRAC_BITS;
            hi_sat = (hsh > H_W'(Q_MAX));
            lo_sat = (hsh < H_W'(Q_MIN));
            side3_next.a[c]  = a2_reg[c];
            side3_next.mr[c] = hi_sat ? Q_MAX : (lo_sat ? Q_MIN : hsh[Q_W-1:0]);
            side3_next.msat  = side3_next.msat | hi_sat | lo_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            side3_reg  <= side3_next;
            sqsum3_reg <= sqsum_next;
        end
    end

    // ---- square root of the exact sum of squares ----
    logic                     sq_out_valid;
    logic                     div_in_ready;
    logic [ROOT_W-1:0]        nrm;
    logic [$bits(sq_side_t)-1:0] sq_out_side;

    qalu_isqrt_pipe #(
        .RAD_W  (RAD_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3_reg),
        .in_ready  (sq_in_ready),
        .in_rad    ({1'b0, sqsum3_reg}),
        .in_side   (side3_reg),
        .out_valid (sq_out_valid),
        .out_ready (div_in_ready),
        .out_root  (nrm),
        .out_side  (sq_out_side)
    );

    // ---- denominator, sign and scalar selection ahead of the divider ----
    sq_side_t                     ss;
    div_side_t                    ds_in;
    logic [N_COMP-1:0][NUM_W-1:0] div_num;
    logic [DEN_W-1:0]             div_den;

    assign ss = sq_side_t'(sq_out_side);

    always_comb begin
        logic [Q_W-1:0] dv_mag;
        logic [Q_W-1:0] a_mag;
        logic           negate;
        logic           dv_zero;
        logic           nsq_zero;
        logic           nrm_zero;
        ds_in    = '0;
        div_num  = '0;
        dv_mag   = ss.dv[Q_W-1] ? (Q_W'(0) - ss.dv) : ss.dv;
        dv_zero  = (ss.dv == '0);
        nsq_zero = (ss.nsq == '0);
        nrm_zero = (nrm == '0);

        ds_in.mulop  = (ss.func == FUNC_MUL);
        ds_in.zflag  = ((ss.func == FUNC_INV) && nsq_zero) ||
                       ((ss.func == FUNC_NORMZ) && nrm_zero);
        ds_in.dzflag = (ss.func == FUNC_DIV) && dv_zero;
        ds_in.qop    = ((ss.func == FUNC_DIV) || (ss.func == FUNC_INV) ||
                        (ss.func == FUNC_NORMZ)) && !ds_in.zflag && !ds_in.dzflag;
        ds_in.mr     = ss.mr;
        ds_in.msat   = ss.msat;

        unique case (ss.func)
            FUNC_DIV:   div_den = DEN_W'(dv_mag);
            FUNC_INV:   div_den = DEN_W'(ss.nsq);
            FUNC_NORMZ: div_den = DEN_W'(nrm);
            default:    div_den = DEN_W'(1);
        endcase

        if (ss.func == FUNC_NSQ) begin
            ds_in.ssat   = (ss.nsq > NSQ_W'(Q_MAX));
            ds_in.scalar = ds_in.ssat ? Q_MAX : ss.nsq[Q_W-1:0];
        end else if (ss.func == FUNC_NORM) begin
            ds_in.ssat   = (nrm > ROOT_W'(Q_MAX));
            ds_in.scalar = ds_in.ssat ? Q_MAX : nrm[Q_W-1:0];
        end

        // conjugate for the inverse, divisor sign for divide
        for (int i = 0; i < N_COMP; i++) begin
            a_mag  = ss.a[i][Q_W-1] ? (Q_W'(0) - ss.a[i]) : ss.a[i];
            negate = ((ss.func == FUNC_DIV) && ss.dv[Q_W-1]) ||
                     ((ss.func == FUNC_INV) && (i != N_COMP - 1));
            ds_in.neg[i] = ss.a[i][Q_W-1] ^ negate;
            div_num[i]   = {a_mag, {FRAC_BITS{1'b0}}};
        end
    end

    // ---- shared bit-serial divider, four lanes ----
    logic                          div_out_valid;
    logic                          out_en;
    logic [N_COMP-1:0][NUM_W-1:0]  quo;
    logic [$bits(div_side_t)-1:0]  div_out_side;

    qalu_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_out_valid),
        .in_ready  (div_in_ready),
        .in_num    (div_num),
        .in_den    (div_den),
        .in_side   (ds_in),
        .out_valid (div_out_valid),
        .out_ready (out_en),
        .out_quo   (quo),
        .out_side  (div_out_side)
    );

    // ---- sign, clamp and result word assembly ----
    div_side_t      ds;
    logic [159:0]   m_tdata_reg;
    logic [159:0]   m_tdata_next;
    logic [1:0]     m_tuser_reg;
    logic [1:0]     m_tuser_next;
    logic           m_valid_reg;

    assign ds     = div_side_t'(div_out_side);
    assign out_en = ~m_valid_reg | m_tready;

    always_comb begin
        logic [Q_W-1:0] val;
        logic [Q_W-1:0] qneg;
        logic           qsat;
        logic           sat;
        m_tdata_next = '0;
        sat          = ds.ssat | (ds.mulop & ds.msat);
        for (int i = 0; i < N_COMP; i++) begin
            qneg = Q_W'(0) - quo[i][Q_W-1:0];
            if (ds.neg[i]) begin
                qsat = (quo[i] > NEG_LIM);
                val  = qsat ? Q_MIN : qneg;
            end else begin
                qsat = (quo[i] > POS_LIM);
                val  = qsat ? Q_MAX : quo[i][Q_W-1:0];
            end
            if (ds.mulop) begin
                m_tdata_next[i*Q_W +: Q_W] = ds.mr[i];
            end else if (ds.qop) begin
                m_tdata_next[i*Q_W +: Q_W] = val;
                sat = sat | qsat;
            end
        end
        m_tdata_next[N_COMP*Q_W +: Q_W] = ds.scalar;

        priority if (ds.zflag) begin
            m_tuser_next = ST_ZERO_NORM;
        end else if (ds.dzflag) begin
            m_tuser_next = ST_DIV_ZERO;
        end else if (sat) begin
            m_tuser_next = ST_SAT;
        end else begin
            m_tuser_next = ST_OK;
        end
    end

    // output register parts the result side from the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---- checks ----
    `QALU_ASSERT_IMP(a_zero_norm_clear, aclk, aresetn,
        m_tvalid && (m_tuser == ST_ZERO_NORM), m_tdata == '0, "zero norm word not cleared")
    `QALU_ASSERT_IMP(a_div_zero_clear, aclk, aresetn,
        m_tvalid && (m_tuser == ST_DIV_ZERO), m_tdata == '0, "divide by zero word not cleared")
    `QALU_ASSERT_IMP(a_sat_nonzero, aclk, aresetn,
        m_tvalid && (m_tuser == ST_SAT), m_tdata != '0, "saturated word carries no bound")
    `QALU_ASSERT_IMP(a_empty_takes, aclk, aresetn,
        !m_tvalid, s_tready, "input stalled with output stage empty")
    `QALU_ASSERT_NXT(a_reset_empty, aclk, !aresetn, !m_tvalid, "output valid after reset")

endmodule

[tb/quaternion_alu_unit_checker.sv]
`timescale 1ns / 100ps

module quaternion_alu_unit_checker
    import qalu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           mismatches,
    output int           pending
);

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic [Q_W-1:0] comp [5];   // r_x, r_y, r_z, r_w, scalar_out
        logic [1:0]     status;
    } qalu_answer_t;

    qalu_answer_t awaited_answers [$];
    string        comp_names [5] = '{"r_x", "r_y", "r_z", "r_w", "scalar_out"};

    function automatic logic [Q_W-1:0] clamp_q(input logic signed [66:0] v, inout bit sat);
        if (v > 67'sd2147483647) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < -67'sd2147483648) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // magnitude division toward zero, sign applied afterwards
    function automatic logic [Q_W-1:0] div_q(input logic signed [66:0] num, input bit negate,
                                             input logic [63:0] den, inout bit sat);
        bit          neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = (num < 0) != negate;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q   = (mag << FB) / den;
        if (neg) begin
            if (q > 64'd2147483648) begin
                sat = 1'b1;
                return Q_MIN;
            end
            return 32'(-q);
        end
        if (q > 64'd2147483647) begin
            sat = 1'b1;
            return Q_MAX;
        end
        return q[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [66:0] v);
        logic [67:0] root;
        logic [67:0] trial;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (68'd1 << b);
            if (trial * trial <= 68'(v))
                root = trial;
        end
        return root[63:0];
    endfunction

    function automatic qalu_answer_t quat_result(input logic [2:0] fn, input logic [287:0] d);
        qalu_answer_t      ans;
        logic signed [66:0] a [4];
        logic signed [66:0] b [4];
        logic signed [66:0] dv;
        logic [66:0]        sumsq;
        logic [63:0]        nsq;
        logic [63:0]        nrm;
        bit                 sat;
        sat = 1'b0;
        for (int i = 0; i < 5; i++)
            ans.comp[i] = '0;
        ans.status = ST_OK;
        for (int i = 0; i < 4; i++) begin
            a[i] = 67'($signed(d[32*i +: 32]));
            b[i] = 67'($signed(d[32*(i+4) +: 32]));
        end
        dv    = 67'($signed(d[256 +: 32]));
        sumsq = '0;
        for (int i = 0; i < 4; i++)
            sumsq = sumsq + 67'(a[i] * a[i]);
        nsq = 64'(sumsq >> FB);
        nrm = int_sqrt(sumsq);
        case (fn)
            FUNC_MUL: begin
                ans.comp[0] = clamp_q((a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1]) >>> FB, sat);
                ans.comp[1] = clamp_q((a[3]*b[1] + a[1]*b[3] + a[2]*b[0] - a[0]*b[2]) >>> FB, sat);
                ans.comp[2] = clamp_q((a[3]*b[2] + a[2]*b[3] + a[0]*b[1] - a[1]*b[0]) >>> FB, sat);
                ans.comp[3] = clamp_q((a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]) >>> FB, sat);
            end
            FUNC_DIV: begin
                if (dv == 0)
                    ans.status = ST_DIV_ZERO;
                else
                    for (int i = 0; i < 4; i++)
                        ans.comp[i] = div_q(a[i], dv < 0, 64'((dv < 0) ? -dv : dv), sat);
            end
            FUNC_INV: begin
                if (nsq == 0)
                    ans.status = ST_ZERO_NORM;
                else
                    for (int i = 0; i < 4; i++)
                        ans.comp[i] = div_q(a[i], i != 3, nsq, sat);
            end
            FUNC_NORMZ: begin
                if (nrm == 0)
                    ans.status = ST_ZERO_NORM;
                else
                    for (int i = 0; i < 4; i++)
                        ans.comp[i] = div_q(a[i], 1'b0, nrm, sat);
            end
            FUNC_NORM: ans.comp[4] = clamp_q(67'(nrm), sat);
            FUNC_NSQ:  ans.comp[4] = clamp_q(67'(nsq), sat);
            default: ;
        endcase
        if (ans.status == ST_OK && sat)
            ans.status = ST_SAT;
        return ans;
    endfunction

    always @(posedge aclk) begin
        qalu_answer_t want;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            mismatches <= 0;
        end else begin
            if (s_tvalid && s_tready)
                awaited_answers.push_back(quat_result(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (awaited_answers.size() == 0) begin
                    $error("result word with no expectation waiting");
                    errs++;
                end else begin
                    want = awaited_answers.pop_front();
                    for (int i = 0; i < 5; i++)
                        if (m_tdata[32*i +: 32] !== want.comp[i]) begin
                            $error("%s expected %h actual %h", comp_names[i], want.comp[i],
                                   m_tdata[32*i +: 32]);
                            errs++;
                        end
                    if (m_tuser !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tuser);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
        end
        pending <= awaited_answers.size();
    end

endmodule

[tb/quaternion_alu_unit_tb.sv]
`timescale 1ns / 100ps

module quaternion_alu_unit_tb;
    import qalu_pkg::*;

    // generous bound, far above the slowest legal run
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 200;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;     // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, divisor
    logic [2:0]   s_tuser;     // func
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;     // r_x, r_y, r_z, r_w, scalar_out
    logic [1:0]   m_tuser;     // status

    int mismatches;
    int pending;
    int cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int phase;

    quaternion_alu_unit dut (.*);

    quaternion_alu_unit_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // cycle counter doubles as the run timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off once idling stops so the
    // pipe fills and the input stalls
    initial begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase == 2 && !held) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // one word onto the input, after a random number of idle cycles
    task automatic push_word(input logic [2:0] fn, input logic [31:0] q [9]);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        for (int i = 0; i < 9; i++)
            s_tdata[32*i +: 32] <= q[i];
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // operand mix: plain Q16.16 magnitudes mostly, full-range and corner values too
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return '0;
            3: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'h0001_0000;
                    3: return 32'hFFFF_0000;
                    default: return 32'h0000_0001;
                endcase
            end
            4:       return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
            default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] ops [9];
        logic [2:0]  fn;
        cycles      = 0;
        phase       = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words
        tx_idle_pct = 10;
        rx_idle_pct = 80;
        for (int k = 0; k < 24; k++) begin
            for (int i = 0; i < 9; i++)
                ops[i] = 32'h0001_8000 + 32'(i << 15);
            fn = FUNC_MUL;
            case (k)
                0:  fn = FUNC_MUL;                                    // small product
                1:  begin ops = '{default: Q_MAX}; fn = FUNC_MUL; end  // saturating product
                2:  begin ops = '{default: Q_MIN}; fn = FUNC_MUL; end
                3:  begin ops = '{default: 32'hFFFF_FFFF}; fn = FUNC_MUL; end
                4:  fn = FUNC_DIV;
                5:  begin ops[8] = '0; fn = FUNC_DIV; end            // zero divisor
                6:  begin ops[0] = Q_MIN; ops[8] = 32'hFFFF_0000; fn = FUNC_DIV; end
                7:  begin ops[8] = 32'h0000_0001; fn = FUNC_DIV; end  // tiny divisor saturates
                8:  fn = FUNC_INV;
                9:  begin                                             // zero norm
                    for (int i = 0; i < 4; i++) ops[i] = '0;
                    fn = FUNC_INV;
                end
                10: begin
                    for (int i = 0; i < 4; i++) ops[i] = 32'h0000_0001;
                    fn = FUNC_INV;
                end
                11: begin
                    for (int i = 0; i < 4; i++) ops[i] = Q_MIN;
                    fn = FUNC_INV;
                end
                12: fn = FUNC_NORMZ;
                13: begin
                    for (int i = 0; i < 4; i++) ops[i] = '0;
                    fn = FUNC_NORMZ;
                end
                14: begin
                    for (int i = 0; i < 4; i++) ops[i] = Q_MIN;
                    fn = FUNC_NORMZ;
                end
                15: begin
                    for (int i = 0; i < 3; i++) ops[i] = '0;
                    ops[3] = 32'h0000_0001;
                    fn = FUNC_NORMZ;
                end
                16: fn = FUNC_NORM;
                17: begin                                             // sum carries
                    for (int i = 0; i < 4; i++) ops[i] = Q_MIN;
                    fn = FUNC_NORM;
                end
                18: begin
                    for (int i = 0; i < 4; i++) ops[i] = Q_MAX;
                    fn = FUNC_NORM;
                end
                19: fn = FUNC_NSQ;
                20: begin
                    for (int i = 0; i < 4; i++) ops[i] = Q_MAX;
                    fn = FUNC_NSQ;
                end
                21: begin
                    for (int i = 0; i < 4; i++) ops[i] = '0;
                    fn = FUNC_NSQ;
                end
                22: fn = 3'd6;                                       // unknown func
                default: fn = 3'd7;
            endcase
            push_word(fn, ops);
        end

        // random words in three idling phases
        for (int p = 0; p < 3; p++) begin
            phase       = p;
            tx_idle_pct = (p == 0) ? 10 : (p == 1) ? 80 : 0;
            rx_idle_pct = (p == 0) ? 80 : (p == 1) ? 10 : 0;
            for (int n = 0; n < 170; n++) begin
                for (int i = 0; i < 9; i++)
                    ops[i] = pick_operand();
                fn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
                push_word(fn, ops);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/qalu_pkg.sv
rtl/core/qalu_isqrt_pipe.sv
rtl/core/qalu_div_pipe.sv
rtl/core/quaternion_alu_unit.sv
tb/quaternion_alu_unit_checker.sv
tb/quaternion_alu_unit_tb.sv
